// ----- hw/rtl/twm_pkg.sv -----
// shared constants and command codes of the trace window mode finder
package twm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int AW         = $clog2(MAX_WINDOW);
	localparam int CNT_W      = 7;
	localparam int ADDR_W     = 16;
	localparam int CMD_W      = 2;

	localparam logic [ADDR_W-1:0] EMPTY_ADDR   = 16'hFFFF;
	localparam logic [CNT_W-1:0]  WINDOW_RESET = CNT_W'(MAX_WINDOW);

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

endpackage

// ----- hw/rtl/trace_window_mode_finder.sv -----
// top level of the trace window mode finder
//
// Input channel (in_valid/in_ready) carries one request: cmd and trace_addr.
// A push stores trace_addr in a 64 entry ring; a clear empties the trace.
// Neither gives a result. An evaluate scans the last w = min(window_size,
// entries held) addresses: for each entry one ring read, then one read per
// window entry to count its matches, all through the single ring read port.
// The result is registered on the output channel (out_valid/out_ready):
// settled_addr and hit_count; the block then returns to idle for the next
// request. An empty window reports 0xFFFF with count zero.
// The block takes one request at a time. Pushes and clears are still taken
// while a result waits on a stalled receiver; an evaluate that finishes
// then holds until the output register is free.
// The user must write window_size through cfg_wr_en/cfg_wr_data only while
// idle; the block itself does not enforce this.
// Reset (arst_n low) empties the trace and sets window_size to 64; ring
// contents are not cleared and are never read before being written.
module trace_window_mode_finder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [twm_pkg::CMD_W-1:0]    cmd,
	input  logic [twm_pkg::ADDR_W-1:0]   trace_addr,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [twm_pkg::ADDR_W-1:0]   settled_addr,
	output logic [twm_pkg::CNT_W-1:0]    hit_count,
	input  logic                         cfg_wr_en,
	input  logic [twm_pkg::CNT_W-1:0]    cfg_wr_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_OUTER = 3'd1;
	localparam logic [2:0] ST_LATCH = 3'd2;
	localparam logic [2:0] ST_INNER = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]                   state_q;
	logic [twm_pkg::CNT_W-1:0]    window_q;
	logic [twm_pkg::AW-1:0]       wr_ptr_q;
	logic [twm_pkg::CNT_W-1:0]    fill_q;
	logic [twm_pkg::CNT_W-1:0]    w_q;
	logic [twm_pkg::AW-1:0]       base_q;
	logic [twm_pkg::CNT_W-1:0]    i_q;
	logic [twm_pkg::CNT_W-1:0]    j_q;
	logic [twm_pkg::CNT_W-1:0]    n_q;
	logic [twm_pkg::ADDR_W-1:0]   cand_q;
	logic [twm_pkg::ADDR_W-1:0]   best_q;
	logic [twm_pkg::CNT_W-1:0]    best_n_q;
	logic                         out_valid_q;
	logic [twm_pkg::ADDR_W-1:0]   out_addr_q;
	logic [twm_pkg::CNT_W-1:0]    out_cnt_q;

	logic                         in_fire;
	logic                         ram_we;
	logic [twm_pkg::AW-1:0]       rd_addr;
	logic [twm_pkg::ADDR_W-1:0]   rd_data;
	logic [twm_pkg::CNT_W-1:0]    w_eff;
	logic [twm_pkg::CNT_W-1:0]    n_sum;
	logic                         out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign ram_we    = in_fire && (cmd == twm_pkg::CMD_PUSH);
	assign out_free  = !out_valid_q || out_ready;

	// effective window: limited by the entries held
	assign w_eff = (window_q > fill_q) ? fill_q : window_q;

	// match count including the compare in flight
	assign n_sum = n_q + twm_pkg::CNT_W'(rd_data == cand_q);

	// ring read address
	always_comb begin
		unique case (state_q)
			ST_OUTER: rd_addr = base_q + i_q[twm_pkg::AW-1:0];
			ST_INNER: rd_addr = base_q + j_q[twm_pkg::AW-1:0];
			default:  rd_addr = base_q;
		endcase
	end

	twm_ram #(
		.WIDTH(twm_pkg::ADDR_W),
		.DEPTH(twm_pkg::MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (trace_addr),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= twm_pkg::WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	// trace pointer and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else if (in_fire && cmd == twm_pkg::CMD_PUSH) begin
			wr_ptr_q <= (wr_ptr_q == twm_pkg::AW'(twm_pkg::MAX_WINDOW - 1)) ?
				'0 : wr_ptr_q + 1'b1;
			if (fill_q != twm_pkg::CNT_W'(twm_pkg::MAX_WINDOW)) begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (in_fire && cmd == twm_pkg::CMD_CLEAR) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end
	end

	// evaluate sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && cmd == twm_pkg::CMD_EVAL) begin
						state_q <= (w_eff == '0) ? ST_FIN : ST_OUTER;
					end
				end
				ST_OUTER: state_q <= ST_LATCH;
				ST_LATCH: state_q <= ST_INNER;
				ST_INNER: begin
					if (j_q == w_q) begin
						state_q <= (i_q + 1'b1 == w_q) ? ST_FIN : ST_OUTER;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scan counters and running best
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				w_q      <= w_eff;
				base_q   <= wr_ptr_q - w_eff[twm_pkg::AW-1:0];
				i_q      <= '0;
				best_q   <= twm_pkg::EMPTY_ADDR;
				best_n_q <= '0;
			end
			ST_LATCH: begin
				cand_q <= rd_data;
				n_q    <= '0;
				j_q    <= twm_pkg::CNT_W'(1);
			end
			ST_INNER: begin
				n_q <= n_sum;
				j_q <= j_q + 1'b1;
				if (j_q == w_q) begin
					i_q <= i_q + 1'b1;
					if (n_sum > best_n_q) begin
						best_n_q <= n_sum;
						best_q   <= cand_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_addr_q <= best_q;
			out_cnt_q  <= best_n_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign settled_addr = out_addr_q;
	assign hit_count    = out_cnt_q;

endmodule

// ----- hw/rtl/twm_ram.sv -----
// generic single write, single read ram with registered read data
module twm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/twm_checker.sv -----
// port level checks of the trace window mode finder, bound to the top level
module twm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [twm_pkg::CMD_W-1:0]    cmd,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [twm_pkg::ADDR_W-1:0]   settled_addr,
	input logic [twm_pkg::CNT_W-1:0]    hit_count
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(settled_addr) && $stable(hit_count))
		else $error("stalled result changed");

	// count never exceeds the ring depth
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit_count <= twm_pkg::CNT_W'(twm_pkg::MAX_WINDOW))
		else $error("hit count above ring depth");

	// empty window reports the empty address
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_count == '0 |-> settled_addr == twm_pkg::EMPTY_ADDR)
		else $error("zero count without empty address");

	// an evaluate request blocks input while it runs
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == twm_pkg::CMD_EVAL |=> !in_ready)
		else $error("input taken during evaluate");

endmodule

bind trace_window_mode_finder twm_checker u_twm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.cmd          (cmd),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.settled_addr (settled_addr),
	.hit_count    (hit_count)
);
